// ----- hdl/sequential_list_engine_defines.svh -----
// Assertion macros for the sequential list engine.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define SLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sequential_list_engine: check failed");
// Check that a condition implies another in the next cycle.
`define SLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequential_list_engine: check failed");
`else
`define SLE_ASSERT_IMP(lbl, ante, cons)
`define SLE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/sle_pkg.sv -----
// Shared types, codes and constants of the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int KIND_W       = 3;
	localparam int POS_W        = 9;
	localparam int WORD_W       = 32;
	localparam int STAT_W       = 2;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_GET    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PRED   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SUCC   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd5;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// One result item as it leaves the sequencer
	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] value;
		logic [POS_W-1:0]  found;
		logic [POS_W-1:0]  length;
	} res_t;

endpackage

// ----- hdl/sle_store.sv -----
// Word store of the list: one write port, one read port with registered data.
`timescale 1ns / 1ps

module sle_store #(
	parameter int DEPTH = sle_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [sle_pkg::WORD_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [sle_pkg::WORD_W-1:0]  rd_data
);

	logic [sle_pkg::WORD_W-1:0] mem_q [DEPTH];
	logic [sle_pkg::WORD_W-1:0] rd_data_q;

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read into the output register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/sle_ctrl.sv -----
// Sequencer of the list engine: decode, search walk and shift walk over the store.
`timescale 1ns / 1ps

module sle_ctrl #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [sle_pkg::KIND_W-1:0]    kind,
	input  logic [sle_pkg::POS_W-1:0]     position,
	input  logic [sle_pkg::WORD_W-1:0]    value,
	output logic                          busy,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [sle_pkg::WORD_W-1:0]    rd_data,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [sle_pkg::WORD_W-1:0]    wr_data,
	output logic                          res_valid,
	output sle_pkg::res_t                 res,
	input  logic                          res_take
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > sle_pkg::POS_W) ? LW : sle_pkg::POS_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_GET,
		S_SCAN,
		S_SUCC,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [sle_pkg::KIND_W-1:0]   kind_q;
	logic [sle_pkg::POS_W-1:0]    pos_q;
	logic [sle_pkg::WORD_W-1:0]   val_q;
	logic [LW-1:0]                len_q;
	logic [AW-1:0]                idx_q;
	logic [sle_pkg::WORD_W-1:0]   prev_q;
	logic [AW-1:0]                ra_q;
	logic [AW-1:0]                wa_q;
	logic [LW-1:0]                cnt_q;
	logic                         pend_q;
	logic                         first_q;
	sle_pkg::status_t             status_q;
	logic [sle_pkg::WORD_W-1:0]   vout_q;
	logic [sle_pkg::POS_W-1:0]    found_q;

	logic [CW-1:0]  pos_x;
	logic [CW-1:0]  len_x;
	logic [CW-1:0]  moves_x;
	logic [CW-1:0]  pos_m1_x;
	logic [CW-1:0]  len_m1_x;
	logic           rd_ok;
	logic           ins_ok;
	logic           full;
	logic           is_del;
	logic [LW-1:0]  nxt;
	logic           nxt_in;
	logic           hit;

	// Position checks and walk bounds
	always_comb begin
		pos_x    = CW'(pos_q);
		len_x    = CW'(len_q);
		moves_x  = len_x - pos_x + CW'(1);
		pos_m1_x = pos_x - CW'(1);
		len_m1_x = len_x - CW'(1);
		rd_ok    = (pos_x != '0) && (pos_x <= len_x);
		ins_ok   = (pos_x != '0) && (pos_x <= len_x + CW'(1));
		full     = (len_q == LW'(CAPACITY));
		is_del   = (kind_q == sle_pkg::KIND_DELETE);
		nxt      = LW'(idx_q) + LW'(1);
		nxt_in   = (nxt < len_q);
		hit      = (rd_data == val_q);
	end

	// Drive the store ports from the current step
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		case (state_q)
			S_DECODE: begin
				case (kind_q)
					sle_pkg::KIND_GET: begin
						rd_en   = rd_ok;
						rd_addr = pos_m1_x[AW-1:0];
					end
					sle_pkg::KIND_LOCATE, sle_pkg::KIND_PRED, sle_pkg::KIND_SUCC: begin
						rd_en   = (len_q != '0);
						rd_addr = '0;
					end
					sle_pkg::KIND_INSERT: begin
						// append needs no shift
						wr_en   = ins_ok && !full && (pos_x == len_x + CW'(1));
						wr_addr = pos_m1_x[AW-1:0];
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				rd_en   = nxt_in;
				rd_addr = nxt[AW-1:0];
			end
			S_SHIFT: begin
				rd_en   = (cnt_q != '0);
				rd_addr = ra_q;
				if (pend_q && !(is_del && first_q)) begin
					wr_en   = 1'b1;
					wr_addr = wa_q;
					wr_data = rd_data;
				end else if (!is_del && (cnt_q == '0) && !pend_q) begin
					wr_en   = 1'b1;
					wr_addr = pos_m1_x[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Sequence one request at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kind_q   <= '0;
			pos_q    <= '0;
			val_q    <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			prev_q   <= '0;
			ra_q     <= '0;
			wa_q     <= '0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			first_q  <= 1'b0;
			status_q <= sle_pkg::ST_BAD;
			vout_q   <= '0;
			found_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// take the request and clear the result fields
					if (req_valid) begin
						kind_q   <= kind;
						pos_q    <= position;
						val_q    <= value;
						vout_q   <= '0;
						found_q  <= '0;
						status_q <= sle_pkg::ST_BAD;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					idx_q   <= '0;
					pend_q  <= 1'b0;
					first_q <= 1'b1;
					case (kind_q)
						sle_pkg::KIND_GET: begin
							state_q <= rd_ok ? S_GET : S_DONE;
						end
						sle_pkg::KIND_LOCATE, sle_pkg::KIND_PRED, sle_pkg::KIND_SUCC: begin
							state_q <= (len_q != '0) ? S_SCAN : S_DONE;
						end
						sle_pkg::KIND_INSERT: begin
							if (!ins_ok) begin
								state_q <= S_DONE;
							end else if (full) begin
								status_q <= sle_pkg::ST_FULL;
								state_q  <= S_DONE;
							end else if (pos_x == len_x + CW'(1)) begin
								len_q    <= len_q + LW'(1);
								status_q <= sle_pkg::ST_OK;
								state_q  <= S_DONE;
							end else begin
								// walk down from the last entry
								ra_q    <= len_m1_x[AW-1:0];
								cnt_q   <= moves_x[LW-1:0];
								state_q <= S_SHIFT;
							end
						end
						sle_pkg::KIND_DELETE: begin
							if (rd_ok) begin
								// walk up from the removed entry
								ra_q    <= pos_m1_x[AW-1:0];
								cnt_q   <= moves_x[LW-1:0];
								state_q <= S_SHIFT;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_GET: begin
					vout_q   <= rd_data;
					status_q <= sle_pkg::ST_OK;
					state_q  <= S_DONE;
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_DONE;
						case (kind_q)
							sle_pkg::KIND_LOCATE: begin
								found_q  <= sle_pkg::POS_W'(nxt);
								status_q <= sle_pkg::ST_OK;
							end
							sle_pkg::KIND_PRED: begin
								if (idx_q != '0) begin
									vout_q   <= prev_q;
									status_q <= sle_pkg::ST_OK;
								end
							end
							sle_pkg::KIND_SUCC: begin
								// the next entry was read alongside this compare
								if (nxt_in) begin
									state_q <= S_SUCC;
								end
							end
							default: begin
							end
						endcase
					end else if (nxt_in) begin
						idx_q  <= nxt[AW-1:0];
						prev_q <= rd_data;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SUCC: begin
					vout_q   <= rd_data;
					status_q <= sle_pkg::ST_OK;
					state_q  <= S_DONE;
				end
				S_SHIFT: begin
					// advance the read pointer, the write trails one step behind
					if (cnt_q != '0) begin
						pend_q <= 1'b1;
						cnt_q  <= cnt_q - LW'(1);
						if (is_del) begin
							wa_q <= ra_q - AW'(1);
							ra_q <= ra_q + AW'(1);
						end else begin
							wa_q <= ra_q + AW'(1);
							ra_q <= ra_q - AW'(1);
						end
					end else begin
						pend_q <= 1'b0;
					end
					// hold the removed word
					if (pend_q && is_del && first_q) begin
						vout_q  <= rd_data;
						first_q <= 1'b0;
					end
					if ((cnt_q == '0) && !pend_q) begin
						len_q    <= is_del ? (len_q - LW'(1)) : (len_q + LW'(1));
						status_q <= sle_pkg::ST_OK;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status = status_q;
		res.value  = vout_q;
		res.found  = found_q;
		res.length = sle_pkg::POS_W'(len_q);
	end

endmodule

// ----- hdl/sequential_list_engine.sv -----
// Sequential list engine: ordered list of signed words with get, search, insert and delete.
//
// Request channel (req_valid / req_stall) carries kind, position and value.
// Response channel (rsp_valid / rsp_stall) carries status, value_out,
// found_index and length_now; every request gives exactly one response.
// A transfer happens on a rising edge with valid high and stall low.
// One request is worked on at a time; req_stall stays high from the transfer
// until its result has moved into the response register.
// Get reads the one addressed entry; bad or full requests and appends walk
//   no entries; locate / predecessor / successor read from the first entry up
//   to the first match, the whole list on a miss; insert and delete move the
//   entries from the position to the end one by one.
// Walks go one store entry a cycle over the single read port.
// The response register holds its result while rsp_stall is high; the next
// request may be taken meanwhile and waits in the sequencer once done.
// Reset empties the list (length zero) at once; no clearing pass is needed.
`timescale 1ns / 1ps
`include "sequential_list_engine_defines.svh"

module sequential_list_engine #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [sle_pkg::KIND_W-1:0]        kind,
	input  logic [sle_pkg::POS_W-1:0]         position,
	input  logic signed [sle_pkg::WORD_W-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [sle_pkg::STAT_W-1:0]        status,
	output logic signed [sle_pkg::WORD_W-1:0] value_out,
	output logic [sle_pkg::POS_W-1:0]         found_index,
	output logic [sle_pkg::POS_W-1:0]         length_now
);

	localparam int AW = $clog2(CAPACITY);

	logic                         busy;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [sle_pkg::WORD_W-1:0]   rd_data;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [sle_pkg::WORD_W-1:0]   wr_data;
	logic                         res_valid;
	sle_pkg::res_t                res;
	logic                         res_take;
	logic                         rsp_valid_q;
	sle_pkg::res_t                rsp_q;

	sle_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.kind      (kind),
		.position  (position),
		.value     (value),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	sle_store #(
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_stall = busy;

	// Load the response register when it is empty or being drained
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (res_take) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_q.status;
	assign value_out   = rsp_q.value;
	assign found_index = rsp_q.found;
	assign length_now  = rsp_q.length;

	// Checks
	`SLE_ASSERT_NXT(a_busy_after_req, req_valid && !busy, busy)
	`SLE_ASSERT_IMP(a_full_len, res_valid && (res.status == sle_pkg::ST_FULL), res.length == sle_pkg::POS_W'(CAPACITY))
	`SLE_ASSERT_IMP(a_bad_zero, res_valid && (res.status != sle_pkg::ST_OK), res.value == '0)
	`SLE_ASSERT_IMP(a_found_ok, res_valid && (res.found != '0), res.status == sle_pkg::ST_OK)

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the sequential list engine: mirrored list, random traffic.
`timescale 1ns / 1ps

module testbench;

	localparam int LIST_CAP = sle_pkg::CAPACITY_DEF;
	localparam logic [sle_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
	localparam logic [sle_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;
	localparam logic signed [sle_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [sle_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [sle_pkg::WORD_W-1:0] WORD_ABSENT = 32'sd1234;
	localparam int POS_TOP = (1 << sle_pkg::POS_W) - 1;
	localparam int SETTLE_CYCLES = LIST_CAP + 40;
	localparam int DRAIN_LIMIT = 50000;
	localparam int LONG_HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [sle_pkg::KIND_W-1:0] kind = '0;
	logic [sle_pkg::POS_W-1:0] position = '0;
	logic signed [sle_pkg::WORD_W-1:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [sle_pkg::STAT_W-1:0] status;
	logic signed [sle_pkg::WORD_W-1:0] value_out;
	logic [sle_pkg::POS_W-1:0] found_index;
	logic [sle_pkg::POS_W-1:0] length_now;

	// Mirror of the list contents and the results still owed by the block
	logic signed [sle_pkg::WORD_W-1:0] mirror_words [LIST_CAP];
	int mirror_len = 0;
	sle_pkg::res_t awaited_answers [$];
	logic signed [sle_pkg::WORD_W-1:0] value_pool [8];
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	int long_hold = 0;
	int unsigned errors = 0;

	sequential_list_engine #(
		.CAPACITY(LIST_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.value_out(value_out),
		.found_index(found_index),
		.length_now(length_now)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// 1-based position of the first entry equal to v, 0 if none
	function automatic int first_hit(logic signed [sle_pkg::WORD_W-1:0] v);
		for (int i = 0; i < mirror_len; i++)
			if (mirror_words[i] == v)
				return i + 1;
		return 0;
	endfunction

	// Apply one request to the mirror and return the result it must give
	function automatic sle_pkg::res_t list_predict(logic [sle_pkg::KIND_W-1:0] k, int p,
			logic signed [sle_pkg::WORD_W-1:0] v);
		sle_pkg::res_t r;
		int m;
		r.status = sle_pkg::ST_BAD;
		r.value = '0;
		r.found = '0;
		m = first_hit(v);
		case (k)
			sle_pkg::KIND_GET: begin
				if (p >= 1 && p <= mirror_len) begin
					r.value = mirror_words[p - 1];
					r.status = sle_pkg::ST_OK;
				end
			end
			sle_pkg::KIND_LOCATE: begin
				r.found = m[sle_pkg::POS_W-1:0];
				if (m != 0)
					r.status = sle_pkg::ST_OK;
			end
			sle_pkg::KIND_PRED: begin
				if (m > 1) begin
					r.value = mirror_words[m - 2];
					r.status = sle_pkg::ST_OK;
				end
			end
			sle_pkg::KIND_SUCC: begin
				if (m != 0 && m < mirror_len) begin
					r.value = mirror_words[m];
					r.status = sle_pkg::ST_OK;
				end
			end
			sle_pkg::KIND_INSERT: begin
				// position is checked ahead of fullness
				if (p >= 1 && p <= mirror_len + 1) begin
					if (mirror_len >= LIST_CAP) begin
						r.status = sle_pkg::ST_FULL;
					end else begin
						for (int j = mirror_len; j >= p; j--)
							mirror_words[j] = mirror_words[j - 1];
						mirror_words[p - 1] = v;
						mirror_len++;
						r.status = sle_pkg::ST_OK;
					end
				end
			end
			sle_pkg::KIND_DELETE: begin
				if (p >= 1 && p <= mirror_len) begin
					r.value = mirror_words[p - 1];
					for (int j = p - 1; j + 1 < mirror_len; j++)
						mirror_words[j] = mirror_words[j + 1];
					mirror_len--;
					r.status = sle_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
		r.length = mirror_len[sle_pkg::POS_W-1:0];
		return r;
	endfunction

	// Offer one request, hold it until the transfer, then record its result
	task automatic send_request(input logic [sle_pkg::KIND_W-1:0] k,
			input logic [sle_pkg::POS_W-1:0] p,
			input logic signed [sle_pkg::WORD_W-1:0] v);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		position <= p;
		value <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		awaited_answers.push_back(list_predict(k, p, v));
	endtask

	// Draw a word: often from a small pool so that duplicates occur
	function automatic logic signed [sle_pkg::WORD_W-1:0] any_word();
		if ($urandom_range(0, 1) == 0)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Draw a search key: mostly a word that is in the list
	function automatic logic signed [sle_pkg::WORD_W-1:0] search_word();
		if (mirror_len > 0 && $urandom_range(0, 9) < 6)
			return mirror_words[$urandom_range(0, mirror_len - 1)];
		return any_word();
	endfunction

	// One random request, steering the length towards target
	task automatic random_request(input int target);
		int roll;
		int len;
		logic [sle_pkg::KIND_W-1:0] any_kind;
		logic [sle_pkg::POS_W-1:0] any_pos;
		roll = $urandom_range(0, 99);
		len = mirror_len;
		any_kind = sle_pkg::KIND_W'($urandom);
		any_pos = sle_pkg::POS_W'($urandom);
		if (roll < 3)
			send_request(any_kind, any_pos, $urandom);
		else if (roll < (len < target ? 48 : 18))
			send_request(sle_pkg::KIND_INSERT, sle_pkg::POS_W'($urandom_range(1, len + 1)),
				any_word());
		else if (roll < 66)
			send_request(sle_pkg::KIND_DELETE,
				sle_pkg::POS_W'(len > 0 ? $urandom_range(1, len) : 1), any_word());
		else if (roll < 76)
			send_request(sle_pkg::KIND_GET, sle_pkg::POS_W'($urandom_range(1, len + 1)),
				any_word());
		else
			send_request(sle_pkg::KIND_W'($urandom_range(sle_pkg::KIND_LOCATE,
				sle_pkg::KIND_SUCC)), any_pos, search_word());
	endtask

	// Empty-list errors, edge positions and words, every kind, missing neighbours
	task automatic test_edges();
		send_request(sle_pkg::KIND_GET, 0, '0);
		send_request(sle_pkg::KIND_DELETE, 1, '0);
		send_request(sle_pkg::KIND_LOCATE, 0, WORD_ABSENT);
		send_request(sle_pkg::KIND_INSERT, 0, WORD_ABSENT);
		send_request(sle_pkg::KIND_INSERT, 1, WORD_MIN);
		send_request(sle_pkg::KIND_INSERT, 2, WORD_MAX);
		send_request(sle_pkg::KIND_INSERT, 1, '0);
		send_request(sle_pkg::KIND_INSERT, 3, -32'sd1);
		send_request(sle_pkg::KIND_GET, 1, '0);
		send_request(sle_pkg::KIND_GET, 4, '0);
		send_request(sle_pkg::KIND_GET, 5, '0);
		send_request(sle_pkg::KIND_GET, sle_pkg::POS_W'(POS_TOP), '1);
		send_request(sle_pkg::KIND_LOCATE, 0, WORD_MAX);
		send_request(sle_pkg::KIND_LOCATE, 0, WORD_ABSENT);
		send_request(sle_pkg::KIND_PRED, 0, '0);
		send_request(sle_pkg::KIND_SUCC, 0, WORD_MAX);
		send_request(sle_pkg::KIND_PRED, 0, WORD_MAX);
		send_request(sle_pkg::KIND_SUCC, 0, '0);
		send_request(sle_pkg::KIND_PRED, 0, WORD_ABSENT);
		send_request(KIND_SPARE6, 1, '0);
		send_request(KIND_SPARE7, 1, WORD_MAX);
		send_request(sle_pkg::KIND_DELETE, 0, '0);
		send_request(sle_pkg::KIND_DELETE, 4, '0);
		send_request(sle_pkg::KIND_DELETE, 1, '0);
	endtask

	// Fill to capacity, try every insert case while full, then shrink again
	task automatic test_full_list();
		while (mirror_len < LIST_CAP)
			send_request(sle_pkg::KIND_INSERT,
				sle_pkg::POS_W'($urandom_range(1, mirror_len + 1)), any_word());
		send_request(sle_pkg::KIND_INSERT, 1, WORD_MAX);
		send_request(sle_pkg::KIND_INSERT, sle_pkg::POS_W'(LIST_CAP + 1), WORD_MIN);
		send_request(sle_pkg::KIND_INSERT, sle_pkg::POS_W'(LIST_CAP + 2), WORD_MIN);
		send_request(sle_pkg::KIND_INSERT, 0, '0);
		send_request(sle_pkg::KIND_INSERT, sle_pkg::POS_W'(POS_TOP), '1);
		send_request(sle_pkg::KIND_GET, sle_pkg::POS_W'(LIST_CAP), '0);
		send_request(sle_pkg::KIND_GET, sle_pkg::POS_W'(LIST_CAP + 1), '0);
		send_request(sle_pkg::KIND_LOCATE, 0, mirror_words[LIST_CAP - 1]);
		send_request(sle_pkg::KIND_SUCC, 0, mirror_words[LIST_CAP - 1]);
		send_request(sle_pkg::KIND_PRED, 0, mirror_words[LIST_CAP - 1]);
		send_request(sle_pkg::KIND_DELETE, sle_pkg::POS_W'(LIST_CAP), '0);
		while (mirror_len > 16)
			send_request(sle_pkg::KIND_DELETE,
				sle_pkg::POS_W'($urandom_range(1, mirror_len)), any_word());
	endtask

	// Mixed traffic in batches, each with its own length target and idling
	task automatic test_mixed_traffic();
		int target;
		for (int b = 0; b < 11; b++) begin
			target = ($urandom_range(0, 4) == 0) ? $urandom_range(180, LIST_CAP)
				: $urandom_range(0, 48);
			send_gaps = ($urandom_range(0, 3) != 0);
			recv_gaps = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 100; n++)
				random_request(target);
		end
	endtask

	// Hold the result side off for a long stretch while requests keep coming
	task automatic test_output_backpressure();
		send_gaps = 1'b0;
		recv_gaps = 1'b1;
		long_hold = LONG_HOLD_CYCLES;
		for (int n = 0; n < 12; n++)
			random_request(8);
	endtask

	// Back-to-back transfers on both sides
	task automatic test_back_to_back();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		for (int n = 0; n < 250; n++)
			random_request(40);
	endtask

	// Stall the result side in random bursts, or for one long stretch on request
	initial begin : result_stall
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				stall_left = long_hold;
				long_hold = 0;
			end else if (stall_left == 0 && recv_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12);
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		sle_pkg::res_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_answers.size() == 0) begin
				$error("result transfer with no request outstanding");
				errors++;
			end else begin
				want = awaited_answers.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					errors++;
				end
				if (value_out !== want.value) begin
					$error("value_out: expected %0d, actual %0d",
						$signed(want.value), value_out);
					errors++;
				end
				if (found_index !== want.found) begin
					$error("found_index: expected %0d, actual %0d", want.found, found_index);
					errors++;
				end
				if (length_now !== want.length) begin
					$error("length_now: expected %0d, actual %0d", want.length, length_now);
					errors++;
				end
			end
		end
	end

	// Run the tests in turn, drain, and give the verdict
	initial begin : run_tests
		int waited;
		value_pool[0] = WORD_MIN;
		value_pool[1] = WORD_MAX;
		value_pool[2] = '0;
		value_pool[3] = -32'sd1;
		value_pool[4] = 32'sd1;
		value_pool[5] = 32'sd5;
		value_pool[6] = $urandom;
		value_pool[7] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edges();
		test_full_list();
		test_mixed_traffic();
		test_output_backpressure();
		test_back_to_back();

		req_valid <= 1'b0;
		waited = 0;
		while (awaited_answers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_answers.size() != 0) begin
			$error("%0d results never arrived", awaited_answers.size());
			errors++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
